FILE: rtl/interleaved_bitmap_pixel_generator_macros.svh
// -----------------------------------------------------------------------------
// Interleaved bitmap pixel generator - assertion macros
// Shared concurrent assertion forms, clocked on clk.
// -----------------------------------------------------------------------------
`ifndef INTERLEAVED_BITMAP_PIXEL_GENERATOR_MACROS_SVH
`define INTERLEAVED_BITMAP_PIXEL_GENERATOR_MACROS_SVH

// Checked only out of reset
`define IBPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define IBPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ibpg_pkg.sv
// -----------------------------------------------------------------------------
// ibpg_pkg
// Types, constants and helpers for the interleaved bitmap pixel generator.
// -----------------------------------------------------------------------------
package ibpg_pkg;

  localparam logic [7:0] LAST_LINE       = 8'd191;
  localparam logic [4:0] LAST_GROUP      = 5'd31;
  localparam logic [2:0] LAST_PIXEL      = 3'd7;
  localparam int         QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [7:0] bitmap_byte;
    logic [7:0] attr_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  screen_x;
    logic [7:0]  screen_y;
    logic [23:0] pixel_rgb;
    logic        group_last;
    logic        frame_last;
    logic [12:0] next_bitmap_offset;
    logic [9:0]  next_attr_offset;
  } out_word_t;

  // One classified group, handed from front to back
  typedef struct packed {
    logic [7:0]  bits;
    logic [2:0]  ink;
    logic [2:0]  paper;
    logic [4:0]  col;
    logic [7:0]  row;
    logic        frame_end;
    logic [12:0] next_bmp;
    logic [9:0]  next_att;
  } desc_t;

  // Memory line to screen row: third, line within cell, cell row
  function automatic logic [7:0] row_of(input logic [7:0] line);
    row_of = {line[7:6], line[2:0], line[5:3]};
  endfunction

  function automatic logic [23:0] palette(input logic [2:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      3'd0:    rgb = 24'h000000;
      3'd1:    rgb = 24'h0000FF;
      3'd2:    rgb = 24'hFF0000;
      3'd3:    rgb = 24'hFF00FF;
      3'd4:    rgb = 24'h00FF00;
      3'd5:    rgb = 24'h00FFFF;
      3'd6:    rgb = 24'hFFFF00;
      default: rgb = 24'hFFFFFF;
    endcase
    palette = rgb;
  endfunction

endpackage

FILE: rtl/ibpg_front.sv
// -----------------------------------------------------------------------------
// ibpg_front
// Accepts byte pairs, tracks the memory line and column, builds descriptors.
// -----------------------------------------------------------------------------
`include "interleaved_bitmap_pixel_generator_macros.svh"

module ibpg_front
  import ibpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output desc_t    q_desc
);

  logic [7:0] line_r, line_nxt;
  logic [4:0] col_r, col_nxt;
  logic [7:0] nrow;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    col_nxt  = col_r + 5'd1;
    line_nxt = line_r;
    if (col_r == LAST_GROUP) begin
      line_nxt = (line_r == LAST_LINE) ? 8'd0 : line_r + 8'd1;
    end
    nrow = row_of(line_nxt);

    q_desc.bits      = in_data.bitmap_byte;
    q_desc.ink       = in_data.attr_byte[2:0];
    q_desc.paper     = in_data.attr_byte[5:3];
    q_desc.col       = col_r;
    q_desc.row       = row_of(line_r);
    q_desc.frame_end = (line_r == LAST_LINE) && (col_r == LAST_GROUP);
    q_desc.next_bmp  = {line_nxt, col_nxt};
    q_desc.next_att  = {nrow[7:3], col_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= 8'd0;
      col_r  <= 5'd0;
    end else if (q_push) begin
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

  `IBPG_ASSERT(a_line_range, line_r <= LAST_LINE, "memory line out of range")
  `IBPG_ASSERT(a_wrap, q_push && q_desc.frame_end |=> line_r == 8'd0 && col_r == 5'd0,
               "counters did not wrap at frame end")

endmodule

FILE: rtl/ibpg_queue.sv
// -----------------------------------------------------------------------------
// ibpg_queue
// Short descriptor queue between front and back.
// -----------------------------------------------------------------------------
`include "interleaved_bitmap_pixel_generator_macros.svh"

module ibpg_queue
  import ibpg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output desc_t pop_desc
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  desc_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = count_r == CNT_FULL;
  assign q_valid  = count_r != '0;
  assign pop_desc = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `IBPG_ASSERT(a_no_overflow, !(push && full), "push into full queue")
  `IBPG_ASSERT(a_no_underflow, pop |-> count_r != '0, "pop from empty queue")

endmodule

FILE: rtl/ibpg_back.sv
// -----------------------------------------------------------------------------
// ibpg_back
// Serialises one descriptor into eight pixels through an output register.
// -----------------------------------------------------------------------------
`include "interleaved_bitmap_pixel_generator_macros.svh"

module ibpg_back
  import ibpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  desc_t     q_desc,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  desc_t      cur_r;
  logic       active_r, active_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r;
  out_word_t  out_data_r, pix;
  logic       load, advance, bit_set;

  assign load    = !out_valid_r || out_ready;
  assign advance = load && active_r;
  assign q_pop   = q_valid && (!active_r || (advance && idx_r == LAST_PIXEL));

  always_comb begin
    bit_set            = cur_r.bits[LAST_PIXEL - idx_r];
    pix.screen_x       = {cur_r.col, idx_r};
    pix.screen_y       = cur_r.row;
    pix.pixel_rgb      = palette(bit_set ? cur_r.ink : cur_r.paper);
    pix.group_last     = idx_r == LAST_PIXEL;
    pix.frame_last     = (idx_r == LAST_PIXEL) && cur_r.frame_end;
    pix.next_bitmap_offset = cur_r.next_bmp;
    pix.next_attr_offset   = cur_r.next_att;

    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (advance) begin
      idx_nxt = idx_r + 3'd1;
      if (idx_r == LAST_PIXEL) begin
        active_nxt = 1'b0;
      end
    end
    // refill from the queue when idle or as the last pixel leaves
    if (q_pop) begin
      active_nxt = 1'b1;
      idx_nxt    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_desc;
    end
    if (advance) begin
      out_data_r <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      if (load) begin
        out_valid_r <= active_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IBPG_ASSERT(a_pop_at_boundary, q_pop |-> !active_r || idx_r == LAST_PIXEL,
               "descriptor taken mid-group")
  `IBPG_ASSERT_ALWAYS(a_idle_reset, !rst_n |=> !out_valid_r && !active_r,
                      "back end not idle after reset")

endmodule

FILE: rtl/interleaved_bitmap_pixel_generator.sv
// Each accepted byte pair passes the descriptor queue and the descriptor
//   register of the pixel serialiser, which emits its eight pixels through the
//   output register, one pixel per cycle while out_ready is high and pairs wait.
// The descriptor queue lets up to QUEUE_DEPTH byte pairs be taken ahead.
// Reset (rst_n low, synchronous): line and column counters to zero, queue
//   and output emptied.
// -----------------------------------------------------------------------------
// interleaved_bitmap_pixel_generator
// Turns bitmap/attribute byte pairs into de-interleaved coloured pixels.
// -----------------------------------------------------------------------------
module interleaved_bitmap_pixel_generator
  import ibpg_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic  q_full, q_push, q_pop, q_valid;
  desc_t push_desc, pop_desc;

  ibpg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  ibpg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .pop_desc  (pop_desc)
  );

  ibpg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_desc    (pop_desc),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb - interleaved bitmap pixel generator
// Streams bitmap/attribute byte pairs into the generator, works out the eight
// pixels of each pair from its own line and column counters, and compares
// every pixel word with the oldest one expected. Covers the colour and
// bitmap extremes, random streams with gaps on both sides, a long output
// hold, and a memory line through its wrap.
// -----------------------------------------------------------------------------
module tb;
  import ibpg_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PAIRS   = 380;
  localparam int FINAL_DRAIN    = 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // Model position in the frame
  logic [7:0] model_line = '0;
  logic [4:0] model_group = '0;

  out_word_t pending_pixels[$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  bit        sender_idle = 1'b1;
  bit        receiver_idle = 1'b1;
  int        hold_len = 0;

  interleaved_bitmap_pixel_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [7:0] screen_row_for(input logic [7:0] line);
    int l;
    l = line;
    return 8'((l / 64) * 64 + (l % 8) * 8 + (l / 8) % 8);
  endfunction

  // Palette index bits: 0 blue, 1 red, 2 green
  function automatic logic [23:0] colour_rgb(input logic [2:0] idx);
    return {{8{idx[1]}}, {8{idx[2]}}, {8{idx[0]}}};
  endfunction

  task automatic predict_group_pixels(input logic [7:0] bmp, input logic [7:0] attr);
    logic [7:0]  row;
    logic [7:0]  nline;
    logic [7:0]  nrow;
    logic [4:0]  ngroup;
    logic        frame_end;
    logic [12:0] nbmp;
    logic [9:0]  natt;
    out_word_t   px;
    row       = screen_row_for(model_line);
    frame_end = (model_line == 8'd191) && (model_group == 5'd31);
    nline     = model_line;
    ngroup    = model_group + 5'd1;
    if (model_group == 5'd31) begin
      nline = (model_line == 8'd191) ? 8'd0 : model_line + 8'd1;
    end
    nrow = screen_row_for(nline);
    nbmp = {nline, ngroup};
    natt = {nrow[7:3], ngroup};
    for (int i = 0; i < 8; i++) begin
      px.screen_x           = {model_group, 3'(i)};
      px.screen_y           = row;
      px.pixel_rgb          = bmp[7 - i] ? colour_rgb(attr[2:0]) : colour_rgb(attr[5:3]);
      px.group_last         = (i == 7);
      px.frame_last         = (i == 7) && frame_end;
      px.next_bitmap_offset = nbmp;
      px.next_attr_offset   = natt;
      pending_pixels.push_back(px);
    end
    model_line  = nline;
    model_group = ngroup;
  endtask

  // Called at the edge that took the previous word
  task automatic send_byte_pair(input logic [7:0] bmp, input logic [7:0] attr);
    int gap;
    gap = sender_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {bmp, attr};
    do @(posedge clk); while (!in_ready);
    predict_group_pixels(bmp, attr);
  endtask

  task automatic send_random_pair();
    send_byte_pair(8'($urandom), 8'($urandom));
  endtask

  function automatic void report_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_pixel(input out_word_t got);
    out_word_t want;
    if (pending_pixels.size() == 0) begin
      $display("%0t: unexpected pixel word %0h", $time, got);
      mismatch_count++;
    end else begin
      want = pending_pixels.pop_front();
      report_field("screen_x", want.screen_x, got.screen_x);
      report_field("screen_y", want.screen_y, got.screen_y);
      report_field("pixel_rgb", want.pixel_rgb, got.pixel_rgb);
      report_field("group_last", want.group_last, got.group_last);
      report_field("frame_last", want.frame_last, got.frame_last);
      report_field("next_bitmap_offset", want.next_bitmap_offset, got.next_bitmap_offset);
      report_field("next_attr_offset", want.next_attr_offset, got.next_attr_offset);
    end
  endtask

  // Pixel sink: random stalls, an occasional long hold, check on every take
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_len != 0) begin
        stall    = hold_len;
        hold_len = 0;
      end else begin
        stall = receiver_idle ? $urandom_range(0, 9) : 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_pixel(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Bitmap extremes, every ink and paper, unused attribute bits set
  task automatic test_colour_extremes();
    logic [7:0] patterns[6];
    patterns = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h80, 8'h01};
    foreach (patterns[i]) send_byte_pair(patterns[i], {2'b00, 3'(i), 3'(7 - i)});
    for (int c = 0; c < 8; c++) begin
      send_byte_pair(8'hF0, {2'(c), 3'(c), 3'(7 - c)});
    end
    send_byte_pair(8'h0F, 8'hC0);
    send_byte_pair(8'hFF, 8'hFF);
    send_byte_pair(8'h00, 8'hFF);
  endtask

  task automatic test_random_stream();
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 40 == 0) begin
        sender_idle   = ($urandom_range(0, 3) != 0);
        receiver_idle = ($urandom_range(0, 3) != 0);
      end
      send_random_pair();
    end
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // Hold the sink while words keep coming so the input stalls
  task automatic test_output_hold();
    sender_idle = 1'b0;
    hold_len    = 150;
    repeat (12) send_random_pair();
    sender_idle = 1'b1;
  endtask

  // Run quickly to group 28 of the current line, then cross the line wrap
  task automatic test_line_wrap();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    while (model_group != 5'd28) send_random_pair();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    send_byte_pair(8'hFF, 8'h07);
    send_byte_pair(8'h00, 8'h38);
    send_byte_pair(8'hA5, 8'h3F);
    send_byte_pair(8'h81, 8'h0A);
    send_byte_pair(8'h7E, 8'h21);
    repeat (20) send_random_pair();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_colour_extremes();
    test_random_stream();
    test_output_hold();
    test_line_wrap();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (FINAL_DRAIN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
